@@ src/ps2sd_pkg.sv @@
`timescale 1ns / 1ps

package ps2sd_pkg;

  localparam int DEF_BUFFER_DEPTH = 32;

  localparam int unsigned FRAME_BITS = 11;
  localparam logic [7:0] BREAK_CODE = 8'hF0;
  localparam logic [7:0] ENTER_CODE = 8'h5A;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;  // '?'
  localparam logic [7:0] ZERO_CHAR = 8'h30;     // '0'
  localparam logic [7:0] NINE_CHAR = 8'h39;     // '9'

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TIMEOUT  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef struct packed {
    op_t         opcode;
    logic        clk_level;
    logic        data_level;
    logic [7:0]  tick_time;
    logic [4:0]  read_index;
  } in_t;

  typedef struct packed {
    logic        in_progress;
    logic        data_available;
    logic        char_stored;
    logic [7:0]  stored_char;
    logic [5:0]  char_count;
    logic [7:0]  read_char;
    logic        error_pending;
    err_t        error_code;
  } out_t;

  // scancode set 2 make codes of the digit keys
  function automatic logic [7:0] decode_digit(input logic [7:0] code);
    logic [7:0] ch;
    unique case (code)
      8'h45:   ch = 8'h30;
      8'h16:   ch = 8'h31;
      8'h1E:   ch = 8'h32;
      8'h26:   ch = 8'h33;
      8'h25:   ch = 8'h34;
      8'h2E:   ch = 8'h35;
      8'h36:   ch = 8'h36;
      8'h3D:   ch = 8'h37;
      8'h3E:   ch = 8'h38;
      8'h46:   ch = 8'h39;
      default: ch = UNKNOWN_CHAR;
    endcase
    return ch;
  endfunction

endpackage

@@ src/ps2sd_ctrl.sv @@
`timescale 1ns / 1ps

module ps2sd_ctrl
  import ps2sd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  localparam int FW = $clog2(BUFFER_DEPTH + 1),
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  in_t           item,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  output out_t          result,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  logic [3:0]    bit_position, bit_position_next;
  logic [10:0]   frame_shift, frame_shift_next;
  logic [7:0]    previous_code, previous_code_next;
  logic          reading, reading_next;
  logic          complete, complete_next;
  logic          edges_enabled, edges_enabled_next;
  logic [7:0]    now_ticks, now_ticks_next;
  logic [7:0]    last_edge_ticks, last_edge_ticks_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic          error_flag, error_flag_next;
  err_t          last_error, last_error_next;
  logic [7:0]    timeout_ticks;

  logic [10:0]   frame_set;
  logic [7:0]    code;
  logic [7:0]    idle_ticks;
  logic          restart_req;
  logic          stored;
  logic [7:0]    schar;

  always_comb begin
    bit_position_next    = bit_position;
    frame_shift_next     = frame_shift;
    previous_code_next   = previous_code;
    reading_next         = reading;
    complete_next        = complete;
    edges_enabled_next   = edges_enabled;
    now_ticks_next       = now_ticks;
    last_edge_ticks_next = last_edge_ticks;
    fill_count_next      = fill_count;
    error_flag_next      = error_flag;
    last_error_next      = last_error;
    restart_req          = 1'b0;
    stored               = 1'b0;
    schar                = '0;
    wr_en                = 1'b0;
    wr_addr              = fill_count[AW-1:0];
    wr_data              = '0;

    // bits past the frame width shift out of the vector and set nothing
    frame_set  = frame_shift | (11'(item.data_level) << bit_position);
    code       = frame_set[8:1];
    idle_ticks = 8'(item.tick_time - last_edge_ticks);

    unique case (item.opcode)
      OP_EDGE: begin
        if (edges_enabled && !item.clk_level) begin
          reading_next         = 1'b1;
          last_edge_ticks_next = now_ticks;
          bit_position_next    = bit_position + 4'd1;
          frame_shift_next     = frame_set;
          if (bit_position_next >= 4'(FRAME_BITS)) begin
            if (previous_code == BREAK_CODE) begin
              if (code == ENTER_CODE) begin
                reading_next       = 1'b0;
                complete_next      = 1'b1;
                edges_enabled_next = 1'b0;
              end else begin
                schar           = decode_digit(code);
                stored          = 1'b1;
                wr_en           = 1'b1;
                wr_data         = schar;
                fill_count_next = fill_count + FW'(1);
                if (fill_count == FW'(BUFFER_DEPTH - 1)) begin
                  restart_req     = 1'b1;
                  error_flag_next = 1'b1;
                  last_error_next = ERR_OVERFLOW;
                end
              end
            end
            previous_code_next = code;
            bit_position_next  = '0;
            frame_shift_next   = '0;
          end
        end
      end
      OP_TICK: begin
        now_ticks_next = item.tick_time;
        if (reading && (idle_ticks > timeout_ticks)) begin
          restart_req     = 1'b1;
          error_flag_next = 1'b1;
          last_error_next = ERR_TIMEOUT;
        end
      end
      OP_RESTART: restart_req = 1'b1;
      OP_READ:    error_flag_next = 1'b0;
      default:    restart_req = 1'b0;
    endcase

    if (restart_req) begin
      bit_position_next  = '0;
      frame_shift_next   = '0;
      fill_count_next    = '0;
      reading_next       = 1'b0;
      complete_next      = 1'b0;
      edges_enabled_next = 1'b1;
      // an overflow restart still keeps the frame's code as previous code
      if (item.opcode != OP_EDGE) begin
        previous_code_next = '0;
      end
    end

    result.in_progress    = reading_next;
    result.data_available = complete_next;
    result.char_stored    = stored;
    result.stored_char    = schar;
    result.char_count     = 6'(fill_count_next);
    result.read_char      = '0;
    result.error_pending  = (item.opcode == OP_READ) ? error_flag : error_flag_next;
    result.error_code     = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position    <= '0;
      frame_shift     <= '0;
      previous_code   <= '0;
      reading         <= 1'b0;
      complete        <= 1'b0;
      edges_enabled   <= 1'b1;
      now_ticks       <= '0;
      last_edge_ticks <= '0;
      fill_count      <= '0;
      error_flag      <= 1'b0;
      last_error      <= ERR_NONE;
      timeout_ticks   <= TIMEOUT_RESET;
    end else begin
      if (accept) begin
        bit_position    <= bit_position_next;
        frame_shift     <= frame_shift_next;
        previous_code   <= previous_code_next;
        reading         <= reading_next;
        complete        <= complete_next;
        edges_enabled   <= edges_enabled_next;
        now_ticks       <= now_ticks_next;
        last_edge_ticks <= last_edge_ticks_next;
        fill_count      <= fill_count_next;
        error_flag      <= error_flag_next;
        last_error      <= last_error_next;
      end
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

endmodule

@@ src/ps2_scancode_digit_receiver_top.sv @@
`timescale 1ns / 1ps

// PS/2 scancode digit receiver.
// Input channel (in_valid / in_stall / in_item) carries one event per
// transaction: a falling clock edge with the line levels, a tick with the
// current tick count, a restart, or a read of one buffer entry with status.
// Every input transaction yields exactly one result transaction on the
// output channel (out_valid / out_stall / out_item).
// The result is registered and shows in out_item the cycle after the input
// is accepted. One item per cycle unless out_stall holds a result; the state
// update, buffer write and registered read all finish in the accepting cycle.
// in_stall rises only while a result is held and out_stall is high, so a
// new transaction is taken in the same cycle the held result leaves.
// The timeout register is written through cfg_valid / cfg_data; cfg_ready
// is always high. Write it only while the block is idle.
// Synchronous reset clears all control state, sets the timeout to 10 ticks
// and re-enables edges; the character buffer is not cleared, and an entry
// that was never written reads back as an unknown value.

module ps2_scancode_digit_receiver_top
  import ps2sd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          accept;
  out_t          result;
  out_t          out_reg;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [31:0]   read_wide;
  logic          read_hit;
  logic          rd_hit;
  logic [7:0]    ram_q;
  logic [7:0]    char_mem [BUFFER_DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign read_wide = 32'(in_item.read_index);
  assign read_hit  = (in_item.opcode == OP_READ) && (read_wide < 32'(BUFFER_DEPTH));

  ps2sd_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (result),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      char_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      ram_q <= char_mem[read_wide[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
      rd_hit  <= read_hit;
    end
  end

  always_comb begin
    out_item           = out_reg;
    out_item.read_char = rd_hit ? ram_q : '0;
  end

endmodule

@@ src/ps2sd_checker.sv @@
`timescale 1ns / 1ps

module ps2sd_checker
  import ps2sd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  // every accepted transaction leaves a result behind it
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted transaction");

  // input side backs up only behind a held result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("held result changed");

  // a finished read and a running read exclude each other
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.in_progress && out_item.data_available))
    else $error("in progress and data available together");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.char_stored) |->
      (out_item.stored_char == UNKNOWN_CHAR ||
       (out_item.stored_char >= ZERO_CHAR && out_item.stored_char <= NINE_CHAR)))
    else $error("stored character is not a digit or unknown mark");

endmodule

bind ps2_scancode_digit_receiver_top ps2sd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/sv/ps2_scancode_digit_receiver_top_test.sv @@
`timescale 1ns / 1ps

module ps2_scancode_digit_receiver_top_test;
  import ps2sd_pkg::*;

  localparam int DEPTH = DEF_BUFFER_DEPTH;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 40;

  typedef enum {ROW_ITEM, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    in_t        item;
    logic [7:0] code;
    bit         typed;
    out_t       res;
  } plan_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  ps2_scancode_digit_receiver_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // receiver model state
  logic [7:0]  m_timeout = TIMEOUT_RESET;
  logic [3:0]  m_bitpos = '0;
  logic [10:0] m_frame = '0;
  logic [7:0]  m_prev = '0;
  logic        m_reading = 1'b0;
  logic        m_complete = 1'b0;
  logic        m_edges_en = 1'b1;
  logic [7:0]  m_now = '0;
  logic [7:0]  m_last_edge = '0;
  int          m_fill = 0;
  logic [7:0]  m_store [DEPTH];
  bit          m_written [DEPTH];
  logic        m_err = 1'b0;
  err_t        m_last_err = ERR_NONE;
  int          written_count = 0;
  bit          event_ignored;

  out_t        awaited_status [$];
  plan_row_t   plan [$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  events_sent = 0;
  int  effective_events = 0;
  int  n_timeouts = 0;
  int  n_overflows = 0;
  int  n_complete = 0;
  int  n_stored = 0;
  bit  gaps_on = 1'b1;
  int  burst_left = 0;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic rnd1();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [4:0] rnd5();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_t event_item(op_t op, logic clk_l, logic dat, logic [7:0] t,
                                     logic [4:0] idx);
    in_t it;
    it.opcode     = op;
    it.clk_level  = clk_l;
    it.data_level = dat;
    it.tick_time  = t;
    it.read_index = idx;
    return it;
  endfunction

  function automatic void clear_scan();
    m_bitpos   = '0;
    m_fill     = 0;
    m_reading  = 1'b0;
    m_frame    = '0;
    m_prev     = '0;
    m_edges_en = 1'b1;
    m_complete = 1'b0;
  endfunction

  // advances the model by one event and returns the status it reports
  function automatic out_t step_receiver(input in_t it);
    out_t       r;
    logic [7:0] code;
    logic [7:0] ch;
    logic [7:0] idle;
    r = '0;
    event_ignored = 1'b0;
    case (it.opcode)
      OP_EDGE: begin
        if (m_edges_en && !it.clk_level) begin
          m_reading   = 1'b1;
          m_last_edge = m_now;
          if (it.data_level && m_bitpos < FRAME_BITS) m_frame[m_bitpos] = 1'b1;
          m_bitpos = m_bitpos + 4'd1;
          if (m_bitpos >= FRAME_BITS) begin
            code = m_frame[8:1];
            if (m_prev == BREAK_CODE) begin
              if (code == ENTER_CODE) begin
                m_reading  = 1'b0;
                m_complete = 1'b1;
                m_edges_en = 1'b0;
                n_complete++;
              end else begin
                case (code)
                  8'h45:   ch = ZERO_CHAR;
                  8'h16:   ch = ZERO_CHAR + 8'd1;
                  8'h1E:   ch = ZERO_CHAR + 8'd2;
                  8'h26:   ch = ZERO_CHAR + 8'd3;
                  8'h25:   ch = ZERO_CHAR + 8'd4;
                  8'h2E:   ch = ZERO_CHAR + 8'd5;
                  8'h36:   ch = ZERO_CHAR + 8'd6;
                  8'h3D:   ch = ZERO_CHAR + 8'd7;
                  8'h3E:   ch = ZERO_CHAR + 8'd8;
                  8'h46:   ch = NINE_CHAR;
                  default: ch = UNKNOWN_CHAR;
                endcase
                r.char_stored = 1'b1;
                r.stored_char = ch;
                n_stored++;
                if (m_fill < DEPTH) begin
                  m_store[m_fill] = ch;
                  if (!m_written[m_fill]) written_count++;
                  m_written[m_fill] = 1'b1;
                end
                m_fill++;
                if (m_fill >= DEPTH) begin
                  clear_scan();
                  m_err      = 1'b1;
                  m_last_err = ERR_OVERFLOW;
                  n_overflows++;
                end
              end
            end
            m_prev   = code;
            m_bitpos = '0;
            m_frame  = '0;
          end
        end else begin
          event_ignored = 1'b1;
        end
        r.error_pending = m_err;
      end
      OP_TICK: begin
        m_now = it.tick_time;
        idle  = m_now - m_last_edge;
        if (m_reading && idle > m_timeout) begin
          clear_scan();
          m_err      = 1'b1;
          m_last_err = ERR_TIMEOUT;
          n_timeouts++;
        end
        r.error_pending = m_err;
      end
      OP_RESTART: begin
        clear_scan();
        r.error_pending = m_err;
      end
      default: begin
        r.read_char     = m_store[it.read_index];
        r.error_pending = m_err;
        m_err           = 1'b0;
      end
    endcase
    r.in_progress    = m_reading;
    r.data_available = m_complete;
    r.char_count     = 6'(m_fill);
    r.error_code     = m_last_err;
    return r;
  endfunction

  function automatic string fmt_status(input out_t r);
    return $sformatf("prog=%0b avail=%0b stored=%0b ch=%02h cnt=%0d rd=%02h pend=%0b err=%0d",
                     r.in_progress, r.data_available, r.char_stored, r.stored_char,
                     r.char_count, r.read_char, r.error_pending, r.error_code);
  endfunction

  task automatic push_item(input in_t it, input bit typed = 1'b0, input out_t fixed = '0);
    out_t res;
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    res = step_receiver(it);
    if (typed) res = fixed;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    awaited_status.push_back(res);
    events_sent++;
    if (!event_ignored) effective_events++;
  endtask

  task automatic push_tick(input bit big);
    logic [7:0] adv;
    adv = big ? m_timeout + 8'd1 + 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 2));
    push_item(event_item(OP_TICK, rnd1(), rnd1(), m_now + adv, rnd5()));
  endtask

  // only entries already written may be read back
  task automatic push_read();
    logic [4:0] idx;
    if (written_count == 0) return;
    do idx = rnd5(); while (!m_written[idx]);
    push_item(event_item(OP_READ, rnd1(), rnd1(), rnd8(), idx));
  endtask

  task automatic push_noise();
    logic [$bits(in_t)-1:0] raw;
    in_t it;
    raw = $bits(in_t)'($urandom);
    it  = in_t'(raw);
    if (it.opcode == OP_READ) push_read();
    else push_item(it);
  endtask

  // start bit, eight data bits lsb first, odd parity, stop bit
  task automatic send_frame(input logic [7:0] code, input bit noisy);
    logic [10:0] bits;
    bits = {1'b1, ~^code, code, 1'b0};
    if (noisy && $urandom_range(0, 9) == 0) bits[0] = 1'b1;
    if (noisy && $urandom_range(0, 9) == 0) bits[9] = ~bits[9];
    if (noisy && $urandom_range(0, 9) == 0) bits[10] = 1'b0;
    for (int b = 0; b < 11; b++) begin
      if (noisy && $urandom_range(0, 19) == 0) push_tick(1'b0);
      if (noisy && $urandom_range(0, 29) == 0)
        push_item(event_item(OP_EDGE, 1'b1, rnd1(), rnd8(), rnd5()));
      push_item(event_item(OP_EDGE, 1'b0, bits[b], rnd8(), rnd5()));
    end
  endtask

  function automatic logic [7:0] pick_code(input bit noisy);
    logic [7:0] digit_codes [10];
    digit_codes = '{8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46};
    if (noisy && $urandom_range(0, 7) == 0) return rnd8();
    if ($urandom_range(0, 11) == 0) return 8'h1C;
    return digit_codes[$urandom_range(0, 9)];
  endfunction

  // one scanner read: per key an optional make code and its break codes, then enter if finish is set
  task automatic run_scan(input int n_chars, input bit compact, input bit noisy,
                          input bit finish);
    logic [7:0] code;
    gaps_on = ($urandom_range(0, 2) != 0);
    if (!m_edges_en || compact || $urandom_range(0, 1))
      push_item(event_item(OP_RESTART, rnd1(), rnd1(), rnd8(), rnd5()));
    for (int i = 0; i < n_chars; i++) begin
      code = pick_code(noisy);
      if (!compact) begin
        send_frame(code, noisy);
        if (noisy && $urandom_range(0, 2) == 0) push_tick(1'b0);
      end
      send_frame(BREAK_CODE, noisy);
      send_frame(code, noisy);
      if (noisy && $urandom_range(0, 3) == 0) push_tick($urandom_range(0, 9) == 0);
    end
    if (finish) begin
      send_frame(ENTER_CODE, noisy);
      send_frame(BREAK_CODE, noisy);
      send_frame(ENTER_CODE, noisy);
    end
    repeat ($urandom_range(0, 3)) push_read();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_timeout = value;
  endtask

  function automatic void plan_item(input in_t it, input bit typed = 1'b0,
                                    input out_t res = '0);
    plan.push_back('{ROW_ITEM, it, 8'h00, typed, res});
  endfunction

  function automatic void plan_frame(input logic [7:0] code);
    plan.push_back('{ROW_FRAME, '0, code, 1'b0, '0});
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (awaited_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: got %s", fmt_status(out_item));
      end else begin
        want = awaited_status.pop_front();
        if (out_item.in_progress !== want.in_progress ||
            out_item.data_available !== want.data_available ||
            out_item.char_stored !== want.char_stored ||
            out_item.stored_char !== want.stored_char ||
            out_item.char_count !== want.char_count ||
            out_item.read_char !== want.read_char ||
            out_item.error_pending !== want.error_pending ||
            out_item.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: want %s", $realtime, fmt_status(want));
            $display("                 got  %s", fmt_status(out_item));
          end
        end
      end
    end
  end

  initial begin : receiver_stall
    int mode;
    int seg;
    int pat;
    pat = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          // long hold-off: the block fills and must stall its input
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(posedge clk);
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (pat % 7 < 3);
          endcase
          pat++;
        end
      end
    end
  end

  initial begin : stimulus
    out_t       idle_res;
    out_t       timeout_res;
    logic [7:0] timeout_plan [5];
    int         phase_start;
    idle_res    = '0;
    timeout_res = '0;
    timeout_res.error_pending = 1'b1;
    timeout_res.error_code    = ERR_TIMEOUT;
    timeout_plan = '{8'd3, 8'd0, 8'd255, 8'd10, 8'd0};
    timeout_plan[3] = 8'($urandom_range(1, 254));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan_item(event_item(OP_TICK, 1'b0, 1'b0, 8'd0, 5'd0), 1'b1, idle_res);
    // edge with the clock line high is ignored
    plan_item(event_item(OP_EDGE, 1'b1, 1'b1, 8'd255, 5'd31), 1'b1, idle_res);
    plan_item(event_item(OP_RESTART, 1'b0, 1'b0, 8'd0, 5'd0), 1'b1, idle_res);
    plan_item(event_item(OP_TICK, 1'b1, 1'b1, 8'd255, 5'd31), 1'b1, idle_res);
    plan_item(event_item(OP_EDGE, 1'b0, 1'b0, 8'd0, 5'd0));
    // idle time exactly at the limit, then one past it across the wrap
    plan_item(event_item(OP_TICK, 1'b0, 1'b0, 8'd9, 5'd0));
    plan_item(event_item(OP_TICK, 1'b0, 1'b0, 8'd10, 5'd0), 1'b1, timeout_res);
    plan_item(event_item(OP_RESTART, 1'b1, 1'b1, 8'd255, 5'd31));
    plan_frame(8'h16);
    plan_frame(BREAK_CODE);
    plan_frame(8'h16);
    plan_frame(BREAK_CODE);
    plan_frame(8'h46);
    plan_frame(BREAK_CODE);
    plan_frame(8'h00);
    plan_frame(BREAK_CODE);
    plan_frame(8'hFF);
    plan_item(event_item(OP_READ, 1'b0, 1'b0, 8'd0, 5'd0));
    plan_item(event_item(OP_READ, 1'b1, 1'b1, 8'd255, 5'd3));
    plan_frame(BREAK_CODE);
    plan_frame(ENTER_CODE);
    // edges stay blocked after the terminator until a restart
    plan_item(event_item(OP_EDGE, 1'b0, 1'b1, 8'd0, 5'd0));
    plan_item(event_item(OP_TICK, 1'b0, 1'b0, 8'd200, 5'd0));
    plan_item(event_item(OP_RESTART, 1'b0, 1'b0, 8'd0, 5'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_FRAME) send_frame(plan[i].code, 1'b0);
      else push_item(plan[i].item, plan[i].typed, plan[i].res);
    end

    foreach (timeout_plan[p]) begin
      drain();
      write_timeout(timeout_plan[p]);
      if (p == 1) hold_req = 1'b1;
      phase_start = effective_events;
      while (effective_events - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          run_scan(1, $urandom_range(0, 1) != 0, 1'b1, $urandom_range(0, 4) != 0);
        else begin
          gaps_on = ($urandom_range(0, 1) != 0);
          repeat ($urandom_range(1, 8)) push_noise();
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);

    $display("sent %0d events (%0d effective) under %0d timeout settings, %0d results checked",
             events_sent, effective_events, $size(timeout_plan), results_checked);
    $display("seen %0d characters stored, %0d timeouts, %0d overflows, %0d completed reads",
             n_stored, n_timeouts, n_overflows, n_complete);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               awaited_status.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
